// ===== hdl/slpr_pkg.sv =====
// Shared constants and the elaboration-time sine table builder for the
// sine LUT point rotator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package slpr_pkg;

   // Operation codes carried in the mode field.
   localparam logic [1:0] MODE_SIN = 2'd0;
   localparam logic [1:0] MODE_COS = 2'd1;
   localparam logic [1:0] MODE_ROT = 2'd2;
   // Bit of the mode field that selects rotation, so the unused code rotates too.
   localparam int MODE_ROT_BIT = 1;

   // Field and table widths.
   localparam int DATA_BITS  = 32;
   localparam int ENTRY_BITS = 18;
   localparam int FRAC_BITS  = 16;
   localparam int PROD_BITS  = DATA_BITS + ENTRY_BITS;

   // Table magnitude at a quarter turn, and pi in Q62.
   localparam int          UNIT_MAG = 65536;
   localparam logic [63:0] PI_Q62   = 64'hC90F_DAA2_2168_C235;

   // Low 64 bits of (a * b) >> sh, for 0 < sh < 64.
   function automatic logic [63:0] mul_shr(input logic [63:0] a,
                                           input logic [63:0] b,
                                           input int          sh);
      logic [127:0] prod;
      logic [127:0] shifted;
      prod    = {64'd0, a} * {64'd0, b};
      shifted = prod >> sh;
      return shifted[63:0];
   endfunction

   // Table entry k of a table with 2**addr_bits steps: sine of the angle
   // times 65536, truncated toward zero. The quarter wave is a Taylor
   // series in Q62 fixed point; the other quarters follow by symmetry.
   // Evaluated only at elaboration with constant arguments.
   function automatic logic signed [ENTRY_BITS-1:0] sine_entry(input int k,
                                                              input int addr_bits);
      int          qbits;
      int          qsteps;
      int          quad;
      int          r;
      int          n;
      int          mag;
      logic [63:0] t;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      qbits  = addr_bits - 2;
      qsteps = 1 << qbits;
      quad   = k >> qbits;
      r      = k & (qsteps - 1);
      if ((quad & 1) != 0) begin
         r = qsteps - r;
      end
      if (r == 0) begin
         mag = 0;
      end else if (r >= qsteps) begin
         mag = UNIT_MAG;
      end else begin
         // 2r/N in Q32, then the angle pi*2r/N in Q62.
         t    = 64'(r) << (33 - addr_bits);
         x    = mul_shr(PI_Q62, t, 32);
         x2   = mul_shr(x, x, 62);
         term = x;
         sum  = x;
         for (n = 1; n < 40 && term != 64'd0; n++) begin
            term = mul_shr(term, x2, 62) / 64'((2 * n) * (2 * n + 1));
            if ((n & 1) != 0) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         mag = int'(sum >> 46);
      end
      if (quad >= 2) begin
         mag = -mag;
      end
      return ENTRY_BITS'(mag);
   endfunction

endpackage

`default_nettype wire

// ===== hdl/slpr_rom.sv =====
// Sine table in read-only memory with two registered read ports.
// Depends on slpr_pkg for the entry width and the table builder.
`timescale 1ns / 1ps
`default_nettype none

module slpr_rom import slpr_pkg::*; #(
   parameter int ADDR_BITS = 10
) (
   input  wire logic                         clock,
   input  wire logic                         rd_en,
   input  wire logic [ADDR_BITS-1:0]         sin_addr,
   input  wire logic [ADDR_BITS-1:0]         cos_addr,
   output logic signed [ENTRY_BITS-1:0]      sin_data_ff,
   output logic signed [ENTRY_BITS-1:0]      cos_data_ff
);

   localparam int DEPTH = 2 ** ADDR_BITS;

   logic signed [ENTRY_BITS-1:0] rom_mem [DEPTH];

   // Table contents are fixed at elaboration.
   for (genvar k = 0; k < DEPTH; k++) begin : g_entry
      assign rom_mem[k] = sine_entry(k, ADDR_BITS);
   end

   // Both ports read in the same cycle; data holds while the pipeline stalls.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         sin_data_ff <= rom_mem[sin_addr];
         cos_data_ff <= rom_mem[cos_addr];
      end
   end

endmodule

`default_nettype wire

// ===== hdl/sine_lut_point_rotator_unit.sv =====
// Sine LUT point rotator: scaled sine, scaled cosine and 2-D point rotation.
// Depends on slpr_pkg and slpr_rom.
//
// Usage:
//   The request channel (req_valid, req_stall, req_*) takes one word per
//   cycle while req_stall is low: mode, angle, x_in, y_in and scale. Mode 0
//   returns (sin * scale) >>> 16, mode 1 returns (cos * scale) >>> 16, and
//   mode 2 (or 3) rotates the point. The response channel (rsp_valid,
//   rsp_stall, rsp_out_x, rsp_out_y) returns one word per request, in order.
//   A word passes from the accepting edge to rsp_valid through three register
//   stages: table read (loaded at the accepting edge), four 32x18 multiplies,
//   then shift and combine into the output register. Throughput is one word
//   per cycle when not stalled, set by the two-port table read and the
//   parallel multipliers; the angle only indexes the table modulo SINE_STEPS.
//   When the receiver stalls, the response holds and earlier stages keep
//   filling until every stage is full; only then is req_stall raised.
//   Synchronous reset empties the pipeline; the table is constant and
//   needs no initialization pass, so a word can be taken right after reset.
`timescale 1ns / 1ps
`default_nettype none

module sine_lut_point_rotator_unit import slpr_pkg::*; #(
   parameter int SINE_STEPS = 1024
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [1:0]                   req_mode,
   input  wire logic [DATA_BITS-1:0]         req_angle,
   input  wire logic signed [DATA_BITS-1:0]  req_x_in,
   input  wire logic signed [DATA_BITS-1:0]  req_y_in,
   input  wire logic signed [DATA_BITS-1:0]  req_scale,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic signed [DATA_BITS-1:0]       rsp_out_x,
   output logic signed [DATA_BITS-1:0]       rsp_out_y
);

   localparam int ADDR_BITS = $clog2(SINE_STEPS);
   localparam int QUARTER   = SINE_STEPS / 4;

   // Stage enables: a stage moves when the next one is empty or moving.
   logic adv1;
   logic adv2;
   logic adv3;

   // Stage 1: table read plus the operands.
   logic                          v1_ff;
   logic [1:0]                    mode1_ff;
   logic signed [DATA_BITS-1:0]   x1_ff;
   logic signed [DATA_BITS-1:0]   y1_ff;
   logic signed [DATA_BITS-1:0]   scale1_ff;
   logic signed [ENTRY_BITS-1:0]  sin1;
   logic signed [ENTRY_BITS-1:0]  cos1;
   logic [ADDR_BITS-1:0]          sin_addr;
   logic [ADDR_BITS-1:0]          cos_addr;

   // Stage 2: registered products.
   logic                          v2_ff;
   logic                          rot2_ff;
   logic signed [PROD_BITS-1:0]   p0_ff;
   logic signed [PROD_BITS-1:0]   p1_ff;
   logic signed [PROD_BITS-1:0]   p2_ff;
   logic signed [PROD_BITS-1:0]   p3_ff;
   logic signed [PROD_BITS-1:0]   p0_in;
   logic signed [PROD_BITS-1:0]   p1_in;
   logic signed [PROD_BITS-1:0]   p2_in;
   logic signed [PROD_BITS-1:0]   p3_in;
   logic signed [DATA_BITS-1:0]   op_a;
   logic signed [ENTRY_BITS-1:0]  op_b;
   logic                          rot1;

   // Stage 3: output register.
   logic                          v3_ff;
   logic signed [DATA_BITS-1:0]   out_x_ff;
   logic signed [DATA_BITS-1:0]   out_y_ff;
   logic signed [DATA_BITS-1:0]   out_x_in;
   logic signed [DATA_BITS-1:0]   out_y_in;
   logic signed [PROD_BITS-1:0]   sh0;
   logic signed [PROD_BITS-1:0]   sh1;
   logic signed [PROD_BITS-1:0]   sh2;
   logic signed [PROD_BITS-1:0]   sh3;

   // Pipeline flow control.
   assign adv3      = !v3_ff || !rsp_stall;
   assign adv2      = !v2_ff || adv3;
   assign adv1      = !v1_ff || adv2;
   assign req_stall = !adv1;

   // Sine index and the cosine index a quarter turn ahead, both modulo the size.
   assign sin_addr = req_angle[ADDR_BITS-1:0];
   assign cos_addr = req_angle[ADDR_BITS-1:0] + ADDR_BITS'(QUARTER);

   slpr_rom #(
      .ADDR_BITS (ADDR_BITS)
   ) u_rom (
      .clock       (clock),
      .rd_en       (adv1),
      .sin_addr    (sin_addr),
      .cos_addr    (cos_addr),
      .sin_data_ff (sin1),
      .cos_data_ff (cos1)
   );

   // Stage 1 operand registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv1) begin
         v1_ff <= req_valid;
      end
      if (adv1) begin
         mode1_ff  <= req_mode;
         x1_ff     <= req_x_in;
         y1_ff     <= req_y_in;
         scale1_ff <= req_scale;
      end
   end

   // Product operands: the first multiplier serves both the scaled table
   // value and x*cos, the others serve rotation only.
   always_comb begin
      rot1 = mode1_ff[MODE_ROT_BIT];
      op_a = rot1 ? x1_ff : scale1_ff;
      op_b = (!rot1 && mode1_ff == MODE_SIN) ? sin1 : cos1;
      p0_in = op_a * op_b;
      p1_in = y1_ff * sin1;
      p2_in = x1_ff * sin1;
      p3_in = y1_ff * cos1;
   end

   // Stage 2 product registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv2) begin
         v2_ff <= v1_ff;
      end
      if (adv2) begin
         rot2_ff <= rot1;
         p0_ff   <= p0_in;
         p1_ff   <= p1_in;
         p2_ff   <= p2_in;
         p3_ff   <= p3_in;
      end
   end

   // Floor shift of each product, then combine and wrap to 32 bits.
   always_comb begin
      sh0 = p0_ff >>> FRAC_BITS;
      sh1 = p1_ff >>> FRAC_BITS;
      sh2 = p2_ff >>> FRAC_BITS;
      sh3 = p3_ff >>> FRAC_BITS;
      if (rot2_ff) begin
         out_x_in = sh0[DATA_BITS-1:0] - sh1[DATA_BITS-1:0];
         out_y_in = sh2[DATA_BITS-1:0] + sh3[DATA_BITS-1:0];
      end else begin
         out_x_in = sh0[DATA_BITS-1:0];
         out_y_in = '0;
      end
   end

   // Stage 3 output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv3) begin
         v3_ff <= v2_ff;
      end
      if (adv3) begin
         out_x_ff <= out_x_in;
         out_y_ff <= out_y_in;
      end
   end

   assign rsp_valid = v3_ff;
   assign rsp_out_x = out_x_ff;
   assign rsp_out_y = out_y_ff;

   // An accepted word always occupies the first stage on the next cycle.
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> v1_ff)
      else $error("accepted word did not enter stage 1");

   // A stalled response is never dropped.
   a_stall_keeps: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("stalled response was lost");

   // The input is refused only when every stage is full and the output stalls.
   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v1_ff && v2_ff && v3_ff && rsp_stall))
      else $error("input stalled with room in the pipeline");

   // Sine and cosine words leave out_y at zero.
   a_zero_y: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && !rot2_ff && adv3) |=> (rsp_out_y == '0))
      else $error("nonzero out_y for a sine or cosine word");

endmodule

`default_nettype wire

// ===== verif/sine_lut_point_rotator_checker.sv =====
// Checker for the sine LUT point rotator: watches both channels, predicts each
// response word from its own sine table and compares in order. Uses slpr_pkg.
`timescale 1ns / 1ps

module sine_lut_point_rotator_checker import slpr_pkg::*; #(
   parameter int SINE_STEPS = 1024
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   input  wire logic                        req_stall,
   input  wire logic [1:0]                  req_mode,
   input  wire logic [DATA_BITS-1:0]        req_angle,
   input  wire logic signed [DATA_BITS-1:0] req_x_in,
   input  wire logic signed [DATA_BITS-1:0] req_y_in,
   input  wire logic signed [DATA_BITS-1:0] req_scale,
   input  wire logic                        rsp_valid,
   input  wire logic                        rsp_stall,
   input  wire logic signed [DATA_BITS-1:0] rsp_out_x,
   input  wire logic signed [DATA_BITS-1:0] rsp_out_y,
   output int                               mismatch_count,
   output int                               words_in_flight
);

   localparam int QUARTER    = SINE_STEPS / 4;
   localparam int REPORT_MAX = 10;

   typedef struct {
      logic [1:0]                  mode;
      logic [DATA_BITS-1:0]        angle;
      logic signed [DATA_BITS-1:0] out_x;
      logic signed [DATA_BITS-1:0] out_y;
   } rotated_word_type;

   int               sine_table [SINE_STEPS];
   rotated_word_type pending_words [$];

   // Low 64 bits of the full 128-bit product shifted right.
   function automatic logic [63:0] product_shifted(input logic [63:0] a,
                                                   input logic [63:0] b,
                                                   input int          sh);
      logic [127:0] wide;
      wide = ({64'd0, a} * {64'd0, b}) >> sh;
      return wide[63:0];
   endfunction

   // Sine magnitude for 0 <= r <= QUARTER, times 65536 and truncated.
   function automatic int quarter_wave_mag(input int r);
      logic [63:0] step_q32;
      logic [63:0] ang;
      logic [63:0] ang_sq;
      logic [63:0] term;
      logic [63:0] acc;
      int          n;
      if (r == 0) begin
         return 0;
      end
      if (r >= QUARTER) begin
         return UNIT_MAG;
      end
      // 2r/N in Q32, then pi times that in Q62, then the odd Taylor series.
      step_q32 = 64'(r) * ((64'd1 << 33) / 64'(SINE_STEPS));
      ang      = product_shifted(PI_Q62, step_q32, 32);
      ang_sq   = product_shifted(ang, ang, 62);
      term     = ang;
      acc      = ang;
      for (n = 1; n < 40 && term != 64'd0; n++) begin
         term = product_shifted(term, ang_sq, 62) / 64'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            acc = acc - term;
         end else begin
            acc = acc + term;
         end
      end
      return int'(acc >> 46);
   endfunction

   // Fill the table once; quadrants follow from quarter-wave symmetry.
   initial begin : build_table
      int k;
      int quad;
      int r;
      int mag;
      for (k = 0; k < SINE_STEPS; k++) begin
         quad = k / QUARTER;
         r    = k % QUARTER;
         if (quad % 2 == 1) begin
            r = QUARTER - r;
         end
         mag = quarter_wave_mag(r);
         sine_table[k] = (quad >= 2) ? -mag : mag;
      end
   end

   // Expected response word for one request word.
   function automatic rotated_word_type predict_word(
         input logic [1:0]                  mode,
         input logic [DATA_BITS-1:0]        angle,
         input logic signed [DATA_BITS-1:0] x_in,
         input logic signed [DATA_BITS-1:0] y_in,
         input logic signed [DATA_BITS-1:0] scale);
      rotated_word_type w;
      longint           s;
      longint           c;
      longint           xl;
      longint           yl;
      longint           xc;
      longint           yc;
      longint           xs;
      longint           ys;
      longint           e;
      w.mode  = mode;
      w.angle = angle;
      s  = sine_table[angle % SINE_STEPS];
      c  = sine_table[(angle + QUARTER) % SINE_STEPS];
      xl = x_in;
      yl = y_in;
      if (mode[MODE_ROT_BIT]) begin
         // Each product is floored by the arithmetic shift before combining.
         xc = (xl * c) >>> FRAC_BITS;
         yc = (yl * c) >>> FRAC_BITS;
         xs = (xl * s) >>> FRAC_BITS;
         ys = (yl * s) >>> FRAC_BITS;
         w.out_x = DATA_BITS'(xc - ys);
         w.out_y = DATA_BITS'(xs + yc);
      end else begin
         e = (mode == MODE_SIN) ? s : c;
         w.out_x = DATA_BITS'((e * longint'(scale)) >>> FRAC_BITS);
         w.out_y = '0;
      end
      return w;
   endfunction

   // Queue a prediction on each accepted request and check each accepted response.
   always @(posedge clock) begin
      rotated_word_type exp_word;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            pending_words.push_back(predict_word(req_mode, req_angle, req_x_in,
                                                 req_y_in, req_scale));
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_words.size() == 0) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < REPORT_MAX) begin
                  $display("%t: response word with nothing pending: x=%0d y=%0d",
                           $realtime, rsp_out_x, rsp_out_y);
               end
            end else begin
               exp_word = pending_words.pop_front();
               if (rsp_out_x !== exp_word.out_x || rsp_out_y !== exp_word.out_y) begin
                  mismatch_count <= mismatch_count + 1;
                  if (mismatch_count < REPORT_MAX) begin
                     $display("%t: mode=%0d angle=%h expected x=%0d y=%0d, got x=%0d y=%0d",
                              $realtime, exp_word.mode, exp_word.angle, exp_word.out_x,
                              exp_word.out_y, rsp_out_x, rsp_out_y);
                  end
               end
            end
         end
      end
      words_in_flight <= pending_words.size();
   end

endmodule

// ===== verif/sine_lut_point_rotator_unit_tb.sv =====
// Testbench top for the sine LUT point rotator: drives directed and random
// request words with varied pacing and gives the verdict. Uses slpr_pkg,
// sine_lut_point_rotator_unit and sine_lut_point_rotator_checker.
`timescale 1ns / 1ps

module sine_lut_point_rotator_unit_tb import slpr_pkg::*; ();

   localparam int         SINE_STEPS       = 1024;
   localparam int         QUARTER          = SINE_STEPS / 4;
   localparam logic [1:0] MODE_ROT_ALT     = 2'd3;
   localparam int         ITEMS_PER_PHASE  = 410;
   localparam int         LONG_HOLD_CYCLES = 200;
   localparam int         DRAIN_CYCLES     = 12;

   logic                        clock     = 1'b0;
   logic                        reset     = 1'b1;
   logic                        req_valid = 1'b0;
   logic [1:0]                  req_mode  = MODE_SIN;
   logic [DATA_BITS-1:0]        req_angle = '0;
   logic signed [DATA_BITS-1:0] req_x_in  = '0;
   logic signed [DATA_BITS-1:0] req_y_in  = '0;
   logic signed [DATA_BITS-1:0] req_scale = '0;
   logic                        rsp_stall = 1'b0;
   wire                         req_stall;
   wire                         rsp_valid;
   wire signed [DATA_BITS-1:0]  rsp_out_x;
   wire signed [DATA_BITS-1:0]  rsp_out_y;
   int                          mismatch_count;
   int                          words_in_flight;

   int send_idle_pct     = 26;
   int recv_idle_pct     = 75;
   bit long_hold_pending = 1'b0;

   sine_lut_point_rotator_unit #(.SINE_STEPS(SINE_STEPS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_mode  (req_mode),
      .req_angle (req_angle),
      .req_x_in  (req_x_in),
      .req_y_in  (req_y_in),
      .req_scale (req_scale),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_out_x (rsp_out_x),
      .rsp_out_y (rsp_out_y)
   );

   sine_lut_point_rotator_checker #(.SINE_STEPS(SINE_STEPS)) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_angle       (req_angle),
      .req_x_in        (req_x_in),
      .req_y_in        (req_y_in),
      .req_scale       (req_scale),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .mismatch_count  (mismatch_count),
      .words_in_flight (words_in_flight)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Offer one request word after a random number of idle cycles, and hold it
   // until it is taken. Valid stays high when words follow back to back.
   task automatic send_word(input logic [1:0]           mode,
                            input logic [DATA_BITS-1:0] angle,
                            input logic [DATA_BITS-1:0] x_in,
                            input logic [DATA_BITS-1:0] y_in,
                            input logic [DATA_BITS-1:0] scale);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode  <= mode;
      req_angle <= angle;
      req_x_in  <= x_in;
      req_y_in  <= y_in;
      req_scale <= scale;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
   endtask

   // Operands lean on the extremes and on the unit amplitude.
   function automatic logic [DATA_BITS-1:0] pick_operand();
      case ($urandom_range(7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return ($urandom_range(1) != 0) ? DATA_BITS'(UNIT_MAG) : -DATA_BITS'(UNIT_MAG);
         3: return DATA_BITS'($urandom_range(131071)) - DATA_BITS'(UNIT_MAG);
         default: return $urandom();
      endcase
   endfunction

   // Angles often land on or next to a quadrant boundary, with random high bits.
   function automatic logic [DATA_BITS-1:0] pick_angle();
      logic [DATA_BITS-1:0] a;
      a = $urandom();
      if ($urandom_range(3) == 0) begin
         a = a - (a % SINE_STEPS) + DATA_BITS'(QUARTER * $urandom_range(3));
         a = a + DATA_BITS'($urandom_range(2)) - 1;
      end
      return a;
   endfunction

   task automatic send_random_words(input int count);
      int i;
      for (i = 0; i < count; i++) begin
         send_word(2'($urandom_range(3)), pick_angle(), pick_operand(), pick_operand(),
                   pick_operand());
      end
   endtask

   // Receiver pacing; a requested long hold is counted out here.
   initial begin : receiver_pacing
      forever begin
         @(posedge clock);
         if (long_hold_pending) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            long_hold_pending = 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   initial begin : stimulus
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed words: table corners, wrap of the angle, both overflow
      // extremes, the unused mode code, and ignored fields holding junk.
      send_word(MODE_SIN, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000, DATA_BITS'(UNIT_MAG));
      send_word(MODE_SIN, DATA_BITS'(QUARTER), 0, 0, DATA_BITS'(UNIT_MAG));
      send_word(MODE_SIN, DATA_BITS'(2 * QUARTER), 0, 0, DATA_BITS'(UNIT_MAG));
      send_word(MODE_SIN, DATA_BITS'(3 * QUARTER), 0, 0, DATA_BITS'(UNIT_MAG));
      send_word(MODE_COS, 32'd0, 0, 0, DATA_BITS'(UNIT_MAG));
      send_word(MODE_COS, DATA_BITS'(QUARTER), 0, 0, DATA_BITS'(UNIT_MAG));
      send_word(MODE_COS, DATA_BITS'(2 * QUARTER), 0, 0, DATA_BITS'(UNIT_MAG));
      send_word(MODE_COS, DATA_BITS'(3 * QUARTER), $urandom(), $urandom(),
                DATA_BITS'(UNIT_MAG));
      send_word(MODE_SIN, DATA_BITS'(3 * QUARTER), 0, 0, 32'h8000_0000);
      send_word(MODE_COS, DATA_BITS'(2 * QUARTER), 0, 0, 32'h8000_0000);
      send_word(MODE_SIN, DATA_BITS'(QUARTER), 0, 0, 32'h7FFF_FFFF);
      send_word(MODE_SIN, 32'hFFFF_FFFF, 0, 0, 32'h7FFF_FFFF);
      send_word(MODE_COS, 32'hFFFF_FFFF, 0, 0, 32'h8000_0000);
      send_word(MODE_SIN, DATA_BITS'(SINE_STEPS + 1), 0, 0, 32'hFFFF_FFFF);
      send_word(MODE_SIN, 32'd37, 0, 0, 32'd0);
      send_word(MODE_ROT, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 0);
      send_word(MODE_ROT, DATA_BITS'(QUARTER), 32'h7FFF_FFFF, 32'h8000_0000, 0);
      send_word(MODE_ROT, DATA_BITS'(QUARTER / 2), 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
      send_word(MODE_ROT, DATA_BITS'(5 * QUARTER / 2), 32'h8000_0000, 32'h8000_0000,
                $urandom());
      send_word(MODE_ROT, DATA_BITS'(3 * QUARTER), 32'hFFFF_FFFF, 32'd1, 0);
      send_word(MODE_ROT_ALT, DATA_BITS'(QUARTER / 2), 32'h7FFF_FFFF, 32'h8000_0000, 0);
      send_word(MODE_ROT_ALT, 32'hFFFF_FFFF, 32'd65536, 32'hFFFF_0000, 0);
      send_word(MODE_ROT, 32'hFFFF_FC00, 32'd0, 32'd0, 32'h7FFF_FFFF);

      // Sender idles lightly, receiver stalls heavily.
      send_random_words(ITEMS_PER_PHASE);

      // Roles swapped.
      send_idle_pct = 75;
      recv_idle_pct = 26;
      send_random_words(ITEMS_PER_PHASE);

      // No idling; a long receiver hold makes the pipeline fill and back up.
      send_idle_pct     = 0;
      recv_idle_pct     = 0;
      long_hold_pending = 1'b1;
      send_random_words(ITEMS_PER_PHASE);

      req_valid <= 1'b0;
      @(posedge clock);
      while (words_in_flight != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("sine_lut_point_rotator_unit_tb: clean");
      end else begin
         $display("sine_lut_point_rotator_unit_tb: errors");
      end
      $finish;
   end

   // Hard stop far beyond the slowest legal run.
   initial begin : watchdog
      #2_000_000;
      $display("sine_lut_point_rotator_unit_tb: errors");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/slpr_pkg.sv
hdl/slpr_rom.sv
hdl/sine_lut_point_rotator_unit.sv
verif/sine_lut_point_rotator_checker.sv
verif/sine_lut_point_rotator_unit_tb.sv
